@@ src/vrp_pkg.sv @@
// ----------------------------------------------------------------------------
// vrp_pkg: shared types, constants and helpers for vertex_rotate_project
// Widths of the rotation stages, the projection datapath and the divider.
// ----------------------------------------------------------------------------
package vrp_pkg;

  localparam int COORD_WIDTH    = 16;
  localparam int TRIG_FRAC_BITS = 14;
  localparam int COORD_FRAC     = 8;
  localparam int FOCAL          = 5;
  localparam int TRIG_WIDTH     = 16;
  localparam int SCALE_WIDTH    = 16;
  localparam int CFG_WIDTH      = 32;
  localparam int CFG_IDX_WIDTH  = 3;

  localparam int SW = COORD_WIDTH + 8;          // rotated coordinate
  localparam int PW = SW + TRIG_WIDTH;          // product
  localparam int RW = PW + 1;                   // sum of two products
  localparam int AW = PW + 3;                   // product times focal
  localparam int NW = AW - COORD_FRAC;          // dividend / quotient bits
  localparam int VW = SW;                       // divisor bits
  localparam int DW = SW + 1;                   // focal plus z, signed
  localparam int FW = NW + 2;                   // signed quotient
  localparam int XW = FW + 2;                   // screen value before clip
  localparam int ZW = PW - 2 * COORD_FRAC + 1;  // depth value before round

  localparam int FIFO_DEPTH = 16;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FRONT_SLOTS = 8;

  localparam logic signed [RW-1:0] ROT_LIM   = RW'(1) <<< (COORD_WIDTH + 6);
  localparam logic signed [RW-1:0] ROT_LIM_N = -ROT_LIM;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_ROT_Z,
    REG_ROT_Y,
    REG_ROT_X,
    REG_SCALE_X,
    REG_SCALE_Y,
    REG_SCALE_Z,
    REG_OFFSET_XY,
    REG_OFFSET_Z
  } cfg_reg_t;

  typedef struct packed {
    logic signed [SW-1:0] x;
    logic signed [SW-1:0] y;
    logic signed [SW-1:0] z;
    logic                 last;
    logic                 sat;
  } vtx_t;

  typedef struct packed {
    logic signed [SW-1:0] a;
    logic signed [SW-1:0] b;
    logic signed [SW-1:0] p;
    logic                 last;
    logic                 sat;
  } rot_t;

  typedef struct packed {
    logic [2*TRIG_WIDTH-1:0] z;
    logic [2*TRIG_WIDTH-1:0] y;
    logic [2*TRIG_WIDTH-1:0] x;
  } trig_cfg_t;

  typedef struct packed {
    logic signed [SCALE_WIDTH-1:0] scale_x;
    logic signed [SCALE_WIDTH-1:0] scale_y;
    logic signed [SCALE_WIDTH-1:0] scale_z;
    logic signed [SCALE_WIDTH-1:0] off_x;
    logic signed [SCALE_WIDTH-1:0] off_y;
    logic signed [SCALE_WIDTH-1:0] off_z;
  } proj_cfg_t;

  typedef struct packed {
    logic [VW-1:0] rem;
    logic [NW-1:0] nq;
    logic          neg;
    logic          lnz;
  } lane_t;

  typedef struct packed {
    logic [VW-1:0]                d;
    logic                         behind;
    logic                         last;
    logic                         sat;
    logic signed [COORD_WIDTH-1:0] depth;
  } com_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] val;
    logic                          sat;
  } clip_t;

  function automatic lane_t div_step(lane_t l, logic [VW-1:0] dv);
    logic [VW:0] t;
    logic [VW:0] df;
    lane_t       o;
    t = {l.rem, l.nq[NW-1]};
    df = t - {1'b0, dv};
    o = l;
    if (t >= {1'b0, dv}) begin
      o.rem = df[VW-1:0];
      o.nq  = {l.nq[NW-2:0], 1'b1};
    end else begin
      o.rem = t[VW-1:0];
      o.nq  = {l.nq[NW-2:0], 1'b0};
    end
    return o;
  endfunction

  function automatic clip_t clip_coord(logic signed [XW-1:0] v);
    logic signed [XW-1:0] hi;
    logic signed [XW-1:0] lo;
    clip_t                o;
    hi = $signed({{(XW-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}});
    lo = ~hi;
    if (v > hi) begin
      o.val = hi[COORD_WIDTH-1:0];
      o.sat = 1'b1;
    end else if (v < lo) begin
      o.val = lo[COORD_WIDTH-1:0];
      o.sat = 1'b1;
    end else begin
      o.val = v[COORD_WIDTH-1:0];
      o.sat = 1'b0;
    end
    return o;
  endfunction

endpackage

@@ src/vrp_rot_stage.sv @@
// ----------------------------------------------------------------------------
// vrp_rot_stage: one plane rotation
// Multiply stage, then sum, floor shift and clamp stage.
// ----------------------------------------------------------------------------
module vrp_rot_stage (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_vld,
  input  vrp_pkg::rot_t                       in_d,
  input  logic [2*vrp_pkg::TRIG_WIDTH-1:0]    sincos,
  output logic                                out_vld,
  output vrp_pkg::rot_t                       out_d
);
  import vrp_pkg::*;

  logic signed [TRIG_WIDTH-1:0] s;
  logic signed [TRIG_WIDTH-1:0] c;
  logic                         m_vld_r;
  logic signed [PW-1:0]         ac_r, bs_r, as_r, bc_r;
  logic signed [SW-1:0]         p_r;
  logic                         last_r, sat_r;
  logic signed [RW-1:0]         na, nb, fa, fb;
  logic signed [SW-1:0]         ca, cb;
  logic                         sa, sb;
  logic                         out_vld_r;
  rot_t                         out_d_r;

  assign s = sincos[2*TRIG_WIDTH-1:TRIG_WIDTH];
  assign c = sincos[TRIG_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      m_vld_r   <= in_vld;
      out_vld_r <= m_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    ac_r   <= in_d.a * c;
    bs_r   <= in_d.b * s;
    as_r   <= in_d.a * s;
    bc_r   <= in_d.b * c;
    p_r    <= in_d.p;
    last_r <= in_d.last;
    sat_r  <= in_d.sat;
    out_d_r <= '{a: ca, b: cb, p: p_r, last: last_r, sat: sat_r | sa | sb};
  end

  always_comb begin
    na = RW'(ac_r) - RW'(bs_r);
    nb = RW'(as_r) + RW'(bc_r);
    fa = na >>> TRIG_FRAC_BITS;
    fb = nb >>> TRIG_FRAC_BITS;
    sa = (fa > ROT_LIM) || (fa < ROT_LIM_N);
    sb = (fb > ROT_LIM) || (fb < ROT_LIM_N);
    if (fa > ROT_LIM)        ca = ROT_LIM[SW-1:0];
    else if (fa < ROT_LIM_N) ca = ROT_LIM_N[SW-1:0];
    else                     ca = fa[SW-1:0];
    if (fb > ROT_LIM)        cb = ROT_LIM[SW-1:0];
    else if (fb < ROT_LIM_N) cb = ROT_LIM_N[SW-1:0];
    else                     cb = fb[SW-1:0];
  end

  assign out_vld = out_vld_r;
  assign out_d   = out_d_r;

endmodule

@@ src/vrp_front.sv @@
// ----------------------------------------------------------------------------
// vrp_front: vertex capture and Z, Y, X rotation pipeline
// Takes one vertex per cycle and hands rotated vertices to the queue.
// ----------------------------------------------------------------------------
module vrp_front (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_vld,
  input  logic signed [vrp_pkg::COORD_WIDTH-1:0] in_x,
  input  logic signed [vrp_pkg::COORD_WIDTH-1:0] in_y,
  input  logic signed [vrp_pkg::COORD_WIDTH-1:0] in_z,
  input  logic                                   in_last,
  input  vrp_pkg::trig_cfg_t                     trig,
  output logic                                   out_vld,
  output vrp_pkg::vtx_t                          out_d
);
  import vrp_pkg::*;

  logic vld_r;
  vtx_t v_r;
  rot_t rz_in, rz_out, ry_in, ry_out, rx_in, rx_out;
  logic rz_vld, ry_vld, rx_vld;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else        vld_r <= in_vld;
  end

  always_ff @(posedge clk) begin
    v_r <= '{x: SW'(in_x), y: SW'(in_y), z: SW'(in_z), last: in_last, sat: 1'b0};
  end

  assign rz_in = '{a: v_r.x, b: v_r.y, p: v_r.z, last: v_r.last, sat: v_r.sat};

  vrp_rot_stage u_rot_z (
    .clk(clk), .rst_n(rst_n), .in_vld(vld_r), .in_d(rz_in), .sincos(trig.z),
    .out_vld(rz_vld), .out_d(rz_out)
  );

  // after Z: x=a, y=b, z=p; Y rotates (z, x)
  assign ry_in = '{a: rz_out.p, b: rz_out.a, p: rz_out.b, last: rz_out.last,
                   sat: rz_out.sat};

  vrp_rot_stage u_rot_y (
    .clk(clk), .rst_n(rst_n), .in_vld(rz_vld), .in_d(ry_in), .sincos(trig.y),
    .out_vld(ry_vld), .out_d(ry_out)
  );

  // after Y: z=a, x=b, y=p; X rotates (y, z)
  assign rx_in = '{a: ry_out.p, b: ry_out.a, p: ry_out.b, last: ry_out.last,
                   sat: ry_out.sat};

  vrp_rot_stage u_rot_x (
    .clk(clk), .rst_n(rst_n), .in_vld(ry_vld), .in_d(rx_in), .sincos(trig.x),
    .out_vld(rx_vld), .out_d(rx_out)
  );

  // after X: y=a, z=b, x=p
  assign out_vld = rx_vld;
  assign out_d   = '{x: rx_out.p, y: rx_out.a, z: rx_out.b, last: rx_out.last,
                     sat: rx_out.sat};

endmodule

@@ src/vrp_fifo.sv @@
// ----------------------------------------------------------------------------
// vrp_fifo: queue between rotation front and projection back
// Small register queue with a fill level warning for the input side.
// ----------------------------------------------------------------------------
module vrp_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  vrp_pkg::vtx_t push_d,
  input  logic          pop,
  output vrp_pkg::vtx_t pop_d,
  output logic          empty,
  output logic          high
);
  import vrp_pkg::*;

  vtx_t               mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_AW:0]   cnt_r, cnt_nxt;
  logic               do_pop;

  assign empty  = (cnt_r == '0);
  assign do_pop = pop && !empty;
  assign pop_d  = mem[rd_ptr_r];
  assign high   = (cnt_r > (FIFO_AW+1)'(FIFO_DEPTH - FRONT_SLOTS));

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !do_pop)      cnt_nxt = cnt_r + 1'b1;
    else if (!push && do_pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push)   wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_d;
  end

endmodule

@@ src/vrp_back.sv @@
// ----------------------------------------------------------------------------
// vrp_back: perspective projection and depth scaling
// Scale products, pipelined restoring divider for x and y, round and clip.
// ----------------------------------------------------------------------------
module vrp_back (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_vld,
  input  vrp_pkg::vtx_t                           in_d,
  input  vrp_pkg::proj_cfg_t                      cfg,
  output logic                                    out_vld,
  output logic signed [vrp_pkg::COORD_WIDTH-1:0]  out_screen_x,
  output logic signed [vrp_pkg::COORD_WIDTH-1:0]  out_screen_y,
  output logic signed [vrp_pkg::COORD_WIDTH-1:0]  out_depth_z,
  output logic                                    out_behind,
  output logic                                    out_sat,
  output logic                                    out_last
);
  import vrp_pkg::*;

  // scale products
  logic                 b0_vld_r;
  logic signed [PW-1:0] px_r, py_r, pz_r;
  logic signed [DW-1:0] d0_r;
  logic                 b0_last_r, b0_sat_r;

  // focal multiply, depth
  logic                 b1_vld_r;
  logic signed [AW-1:0] ax_r, ay_r;
  logic signed [DW-1:0] d1_r;
  logic                 b1_behind_r, b1_last_r, b1_sat_r;
  logic signed [COORD_WIDTH-1:0] b1_depth_r;
  logic signed [AW-1:0] ax5, ay5;
  logic signed [ZW-2:0] zh;
  logic signed [ZW-1:0] zf;
  logic signed [ZW:0]   zr;
  clip_t                zc;

  // divider
  logic [NW:0] dv_r;
  lane_t       lx_r [NW+1];
  lane_t       ly_r [NW+1];
  com_t        cm_r [NW+1];
  logic [AW-1:0] mx, my;

  // sign restore, offset
  logic                 f1_vld_r;
  logic signed [FW-1:0] qx_r, qy_r;
  logic                 rx_nz_r, ry_nz_r;
  com_t                 f1_cm_r;
  logic signed [FW-1:0] q0x, q0y;
  logic                 nzx, nzy;
  logic signed [XW-1:0] flx, fly, rx, ry;
  clip_t                cx, cy;

  logic                          o_vld_r;
  logic signed [COORD_WIDTH-1:0] o_x_r, o_y_r, o_z_r;
  logic                          o_behind_r, o_sat_r, o_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_vld_r <= 1'b0;
      b1_vld_r <= 1'b0;
      dv_r     <= '0;
      f1_vld_r <= 1'b0;
      o_vld_r  <= 1'b0;
    end else begin
      b0_vld_r <= in_vld;
      b1_vld_r <= b0_vld_r;
      dv_r     <= {dv_r[NW-1:0], b1_vld_r};
      f1_vld_r <= dv_r[NW];
      o_vld_r  <= f1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    px_r      <= in_d.x * cfg.scale_x;
    py_r      <= in_d.y * cfg.scale_y;
    pz_r      <= in_d.z * cfg.scale_z;
    d0_r      <= DW'(in_d.z) + DW'(FOCAL << COORD_FRAC);
    b0_last_r <= in_d.last;
    b0_sat_r  <= in_d.sat;
  end

  always_comb begin
    ax5 = (AW'(px_r) <<< 2) + AW'(px_r);
    ay5 = (AW'(py_r) <<< 2) + AW'(py_r);
    zh  = pz_r[PW-1:2*COORD_FRAC];
    zf  = ZW'(zh) + ZW'(cfg.off_z);
    if ((|pz_r[2*COORD_FRAC-1:0]) && (zf < 0)) zr = (ZW+1)'(zf) + (ZW+1)'(1);
    else                                       zr = (ZW+1)'(zf);
    zc  = clip_coord(XW'(zr));
  end

  always_ff @(posedge clk) begin
    ax_r        <= ax5;
    ay_r        <= ay5;
    d1_r        <= d0_r;
    b1_behind_r <= (d0_r <= 0);
    b1_last_r   <= b0_last_r;
    b1_sat_r    <= b0_sat_r | zc.sat;
    b1_depth_r  <= zc.val;
  end

  always_comb begin
    mx = (ax_r < 0) ? AW'(-ax_r) : AW'(ax_r);
    my = (ay_r < 0) ? AW'(-ay_r) : AW'(ay_r);
  end

  always_ff @(posedge clk) begin
    lx_r[0] <= '{rem: '0, nq: mx[AW-1:COORD_FRAC], neg: ax_r < 0,
                 lnz: |mx[COORD_FRAC-1:0]};
    ly_r[0] <= '{rem: '0, nq: my[AW-1:COORD_FRAC], neg: ay_r < 0,
                 lnz: |my[COORD_FRAC-1:0]};
    cm_r[0] <= '{d: d1_r[VW-1:0], behind: b1_behind_r, last: b1_last_r,
                 sat: b1_sat_r, depth: b1_depth_r};
    for (int g = 0; g < NW; g++) begin
      lx_r[g+1] <= div_step(lx_r[g], cm_r[g].d);
      ly_r[g+1] <= div_step(ly_r[g], cm_r[g].d);
      cm_r[g+1] <= cm_r[g];
    end
  end

  always_comb begin
    nzx = (lx_r[NW].rem != '0) || lx_r[NW].lnz;
    nzy = (ly_r[NW].rem != '0) || ly_r[NW].lnz;
    q0x = $signed({2'b00, lx_r[NW].nq});
    q0y = $signed({2'b00, ly_r[NW].nq});
  end

  always_ff @(posedge clk) begin
    qx_r    <= lx_r[NW].neg ? (-q0x - FW'(nzx)) : q0x;
    qy_r    <= ly_r[NW].neg ? (-q0y - FW'(nzy)) : q0y;
    rx_nz_r <= nzx;
    ry_nz_r <= nzy;
    f1_cm_r <= cm_r[NW];
  end

  always_comb begin
    flx = XW'(qx_r) + XW'(cfg.off_x);
    fly = XW'(qy_r) + XW'(cfg.off_y);
    rx  = (rx_nz_r && (flx < 0)) ? flx + XW'(1) : flx;
    ry  = (ry_nz_r && (fly < 0)) ? fly + XW'(1) : fly;
    cx  = clip_coord(rx);
    cy  = clip_coord(ry);
  end

  always_ff @(posedge clk) begin
    o_behind_r <= f1_cm_r.behind;
    o_last_r   <= f1_cm_r.last;
    o_z_r      <= f1_cm_r.depth;
    if (f1_cm_r.behind) begin
      o_x_r   <= '0;
      o_y_r   <= '0;
      o_sat_r <= f1_cm_r.sat;
    end else begin
      o_x_r   <= cx.val;
      o_y_r   <= cy.val;
      o_sat_r <= f1_cm_r.sat | cx.sat | cy.sat;
    end
  end

  assign out_vld      = o_vld_r;
  assign out_screen_x = o_x_r;
  assign out_screen_y = o_y_r;
  assign out_depth_z  = o_z_r;
  assign out_behind   = o_behind_r;
  assign out_sat      = o_sat_r;
  assign out_last     = o_last_r;

endmodule

@@ src/vertex_rotate_project.sv @@
// ----------------------------------------------------------------------------
// vertex_rotate_project: Euler rotation and perspective projection
// Rotates a vertex about Z, Y, X and projects it with focal constant 5.
// ----------------------------------------------------------------------------
// A vertex transfers on each clock edge with start high and busy low; one
// vertex per clock is sustained and busy stays low outside reset. The result
// strobe out_valid rises once the vertex has passed rotation, the queue,
// scaling and sign handling and 35 steps of the pipelined divider for
// x*scale*5/(5+z). Results come in input order and must be taken in the cycle
// they are shown. Write configuration while idle.
// ----------------------------------------------------------------------------
module vertex_rotate_project (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic signed [vrp_pkg::COORD_WIDTH-1:0] in_vertex_x,
  input  logic signed [vrp_pkg::COORD_WIDTH-1:0] in_vertex_y,
  input  logic signed [vrp_pkg::COORD_WIDTH-1:0] in_vertex_z,
  input  logic                                   in_last_vertex,
  output logic                                   out_valid,
  output logic signed [vrp_pkg::COORD_WIDTH-1:0] out_screen_x,
  output logic signed [vrp_pkg::COORD_WIDTH-1:0] out_screen_y,
  output logic signed [vrp_pkg::COORD_WIDTH-1:0] out_depth_z,
  output logic                                   out_behind_eye,
  output logic                                   out_saturated,
  output logic                                   out_last_out,
  input  logic                                   cfg_we,
  input  logic [vrp_pkg::CFG_IDX_WIDTH-1:0]      cfg_index,
  input  logic [vrp_pkg::CFG_WIDTH-1:0]          cfg_wdata
);
  import vrp_pkg::*;

  localparam int LAT = NW + 13;

  trig_cfg_t trig_r;
  proj_cfg_t proj_r;
  logic      fifo_high, fifo_empty, acc;
  logic      f_vld;
  vtx_t      f_d, q_d;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trig_r.z      <= (2*TRIG_WIDTH)'(1 << TRIG_FRAC_BITS);
      trig_r.y      <= (2*TRIG_WIDTH)'(1 << TRIG_FRAC_BITS);
      trig_r.x      <= (2*TRIG_WIDTH)'(1 << TRIG_FRAC_BITS);
      proj_r.scale_x <= SCALE_WIDTH'(1 << COORD_FRAC);
      proj_r.scale_y <= SCALE_WIDTH'(1 << COORD_FRAC);
      proj_r.scale_z <= SCALE_WIDTH'(1 << COORD_FRAC);
      proj_r.off_x   <= '0;
      proj_r.off_y   <= '0;
      proj_r.off_z   <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_ROT_Z:     trig_r.z <= cfg_wdata[2*TRIG_WIDTH-1:0];
        REG_ROT_Y:     trig_r.y <= cfg_wdata[2*TRIG_WIDTH-1:0];
        REG_ROT_X:     trig_r.x <= cfg_wdata[2*TRIG_WIDTH-1:0];
        REG_SCALE_X:   proj_r.scale_x <= cfg_wdata[SCALE_WIDTH-1:0];
        REG_SCALE_Y:   proj_r.scale_y <= cfg_wdata[SCALE_WIDTH-1:0];
        REG_SCALE_Z:   proj_r.scale_z <= cfg_wdata[SCALE_WIDTH-1:0];
        REG_OFFSET_XY: begin
          proj_r.off_x <= cfg_wdata[2*SCALE_WIDTH-1:SCALE_WIDTH];
          proj_r.off_y <= cfg_wdata[SCALE_WIDTH-1:0];
        end
        REG_OFFSET_Z:  proj_r.off_z <= cfg_wdata[SCALE_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  assign busy = !rst_n || fifo_high;
  assign acc  = start && !busy;

  vrp_front u_front (
    .clk(clk), .rst_n(rst_n), .in_vld(acc),
    .in_x(in_vertex_x), .in_y(in_vertex_y), .in_z(in_vertex_z),
    .in_last(in_last_vertex), .trig(trig_r),
    .out_vld(f_vld), .out_d(f_d)
  );

  vrp_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .push(f_vld), .push_d(f_d),
    .pop(!fifo_empty), .pop_d(q_d), .empty(fifo_empty), .high(fifo_high)
  );

  vrp_back u_back (
    .clk(clk), .rst_n(rst_n), .in_vld(!fifo_empty), .in_d(q_d), .cfg(proj_r),
    .out_vld(out_valid), .out_screen_x(out_screen_x), .out_screen_y(out_screen_y),
    .out_depth_z(out_depth_z), .out_behind(out_behind_eye),
    .out_sat(out_saturated), .out_last(out_last_out)
  );

  a_no_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised outside reset");

  a_behind_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_behind_eye |-> out_screen_x == '0 && out_screen_y == '0)
    else $error("behind-eye result with nonzero screen coordinates");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result without matching transfer");

endmodule

@@ test/vertex_rotate_project_tb.sv @@
// ----------------------------------------------------------------------------
// vertex_rotate_project_tb: self-checking bench for vertex_rotate_project
// Sends a directed table, then random vertices under a series of register
// settings. Results are checked against table values or a bit-exact model.
// ----------------------------------------------------------------------------
module vertex_rotate_project_tb;
  import vrp_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int DRAIN_CYCLES = 60;

  typedef struct {
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic signed [15:0] dz;
    logic               behind;
    logic               sat;
    logic               last;
  } proj_res_t;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic               last;
    bit                 fixed;
    proj_res_t          res;
  } vec_row_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic signed [15:0]      in_vertex_x = '0;
  logic signed [15:0]      in_vertex_y = '0;
  logic signed [15:0]      in_vertex_z = '0;
  logic                    in_last_vertex = 1'b0;
  logic                    out_valid;
  logic signed [15:0]      out_screen_x;
  logic signed [15:0]      out_screen_y;
  logic signed [15:0]      out_depth_z;
  logic                    out_behind_eye;
  logic                    out_saturated;
  logic                    out_last_out;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_WIDTH-1:0] cfg_index = '0;
  logic [CFG_WIDTH-1:0]    cfg_wdata = '0;

  logic [31:0] trig_z, trig_y, trig_x, offs_xy;
  logic [15:0] gain_x, gain_y, gain_z, offs_z;

  proj_res_t  pending_q[$];
  proj_res_t  fixed_q[$];
  bit         fixed_flag_q[$];
  int         cycles = 0;
  bit         failed = 1'b0;
  bit         calm = 1'b0;

  vertex_rotate_project dut (.*);

  always #5 clk = ~clk;

  function automatic longint lim_stage(longint v, ref bit sat);
    if (v < -(64'sd1 <<< 22)) begin
      sat = 1'b1;
      return -(64'sd1 <<< 22);
    end
    if (v > (64'sd1 <<< 22)) begin
      sat = 1'b1;
      return 64'sd1 <<< 22;
    end
    return v;
  endfunction

  function automatic longint lim_coord(longint v, ref bit sat);
    if (v < -32768) begin
      sat = 1'b1;
      return -32768;
    end
    if (v > 32767) begin
      sat = 1'b1;
      return 32767;
    end
    return v;
  endfunction

  function automatic void spin(ref longint a, ref longint b, input logic [31:0] w,
                               ref bit sat);
    longint s, c, na, nb;
    s = longint'($signed(w[31:16]));
    c = longint'($signed(w[15:0]));
    na = (a * c - b * s) >>> TRIG_FRAC_BITS;
    nb = (a * s + b * c) >>> TRIG_FRAC_BITS;
    a = lim_stage(na, sat);
    b = lim_stage(nb, sat);
  endfunction

  function automatic proj_res_t project_vertex(logic signed [15:0] vx, logic signed [15:0] vy,
                                               logic signed [15:0] vz, logic lst);
    longint x, y, z, d, den;
    bit sat;
    proj_res_t r;
    sat = 1'b0;
    x = vx;
    y = vy;
    z = vz;
    spin(x, y, trig_z, sat);
    spin(z, x, trig_y, sat);
    spin(y, z, trig_x, sat);
    d = 1280 + z;
    r.behind = (d <= 0);
    r.sx = '0;
    r.sy = '0;
    if (!r.behind) begin
      den = d * 256;
      r.sx = 16'(lim_coord((x * longint'($signed(gain_x)) * 5 +
                            longint'($signed(offs_xy[31:16])) * den) / den, sat));
      r.sy = 16'(lim_coord((y * longint'($signed(gain_y)) * 5 +
                            longint'($signed(offs_xy[15:0])) * den) / den, sat));
    end
    r.dz = 16'(lim_coord((z * longint'($signed(gain_z)) +
                          longint'($signed(offs_z)) * 65536) / 65536, sat));
    r.sat = sat;
    r.last = lst;
    return r;
  endfunction

  task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    case (idx)
      REG_ROT_Z:     trig_z = val;
      REG_ROT_Y:     trig_y = val;
      REG_ROT_X:     trig_x = val;
      REG_SCALE_X:   gain_x = val[15:0];
      REG_SCALE_Y:   gain_y = val[15:0];
      REG_SCALE_Z:   gain_z = val[15:0];
      REG_OFFSET_XY: offs_xy = val;
      default:       offs_z = val[15:0];
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic send(logic signed [15:0] x, logic signed [15:0] y, logic signed [15:0] z,
                      logic lst, bit fixed, proj_res_t res);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 20) begin
      start = 1'b0;
      @(negedge clk);
    end
    fixed_flag_q.push_back(fixed);
    if (fixed)
      fixed_q.push_back(res);
    start = 1'b1;
    in_vertex_x = x;
    in_vertex_y = y;
    in_vertex_z = z;
    in_last_vertex = lst;
    @(posedge clk);
    while (busy)
      @(posedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (pending_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] trig_word();
    real a;
    int s, c;
    if ($urandom_range(3) == 0)
      return $urandom;
    a = $urandom_range(62831) / 10000.0;
    s = $rtoi(16384.0 * $sin(a));
    c = $rtoi(16384.0 * $cos(a));
    return {16'(s), 16'(c)};
  endfunction

  always @(posedge clk) begin
    proj_res_t exp_r;
    bit fx;
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("vertex_rotate_project verification failed");
      $finish;
    end
    if (rst_n && start && !busy) begin
      fx = fixed_flag_q.pop_front();
      exp_r = project_vertex(in_vertex_x, in_vertex_y, in_vertex_z, in_last_vertex);
      if (fx)
        exp_r = fixed_q.pop_front();
      pending_q.push_back(exp_r);
    end
    if (rst_n && out_valid) begin
      if (pending_q.size() == 0) begin
        $error("result with no vertex pending");
        failed = 1'b1;
      end else begin
        exp_r = pending_q.pop_front();
        if (out_screen_x !== exp_r.sx) begin
          $error("screen_x expected %0d actual %0d", exp_r.sx, out_screen_x);
          failed = 1'b1;
        end
        if (out_screen_y !== exp_r.sy) begin
          $error("screen_y expected %0d actual %0d", exp_r.sy, out_screen_y);
          failed = 1'b1;
        end
        if (out_depth_z !== exp_r.dz) begin
          $error("depth_z expected %0d actual %0d", exp_r.dz, out_depth_z);
          failed = 1'b1;
        end
        if (out_behind_eye !== exp_r.behind) begin
          $error("behind_eye expected %0b actual %0b", exp_r.behind, out_behind_eye);
          failed = 1'b1;
        end
        if (out_saturated !== exp_r.sat) begin
          $error("saturated expected %0b actual %0b", exp_r.sat, out_saturated);
          failed = 1'b1;
        end
        if (out_last_out !== exp_r.last) begin
          $error("last_out expected %0b actual %0b", exp_r.last, out_last_out);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin
    vec_row_t table_rows[$];
    proj_res_t none;
    int z;
    logic signed [15:0] vz;
    none = '{default: '0};
    trig_z = 32'd16384;
    trig_y = 32'd16384;
    trig_x = 32'd16384;
    gain_x = 16'd256;
    gain_y = 16'd256;
    gain_z = 16'd256;
    offs_xy = '0;
    offs_z = '0;

    table_rows = '{
      '{0, 0, 0, 0, 1, '{0, 0, 0, 0, 0, 0}},
      '{256, 0, 0, 1, 1, '{1, 0, 0, 0, 0, 1}},
      '{-32768, 0, 0, 0, 1, '{-128, 0, 0, 0, 0, 0}},
      '{0, 0, -1280, 1, 1, '{0, 0, -5, 1, 0, 1}},
      '{0, 0, 32767, 0, 1, '{0, 0, 127, 0, 0, 0}},
      '{32767, 32767, 32767, 1, 0, none},
      '{-32768, -32768, -32768, 0, 0, none},
      '{32767, -32768, -1279, 0, 0, none},
      '{-32768, 32767, -1281, 1, 0, none},
      '{-1, -1, -1, 1, 0, none},
      '{21845, -21846, 0, 0, 0, none},
      '{-21846, 21845, -21846, 1, 0, none}
    };

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (table_rows[i])
      send(table_rows[i].x, table_rows[i].y, table_rows[i].z, table_rows[i].last,
           table_rows[i].fixed, table_rows[i].res);
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_ROT_Z, 32'h7FFF7FFF);
          write_reg(REG_ROT_Y, 32'h80008000);
          write_reg(REG_ROT_X, 32'h7FFF8000);
          write_reg(REG_SCALE_X, 32'h7FFF);
          write_reg(REG_SCALE_Y, 32'h8000);
          write_reg(REG_SCALE_Z, 32'h7FFF);
          write_reg(REG_OFFSET_XY, 32'h7FFF8000);
          write_reg(REG_OFFSET_Z, 32'h8000);
        end
        1: begin
          write_reg(REG_ROT_Z, 32'h0);
          write_reg(REG_ROT_Y, 32'h0);
          write_reg(REG_ROT_X, 32'h0);
          write_reg(REG_SCALE_X, 32'h8000);
          write_reg(REG_SCALE_Y, 32'h7FFF);
          write_reg(REG_SCALE_Z, 32'h8000);
          write_reg(REG_OFFSET_XY, 32'h80007FFF);
          write_reg(REG_OFFSET_Z, 32'h7FFF);
        end
        default: begin
          write_reg(REG_ROT_Z, trig_word());
          write_reg(REG_ROT_Y, trig_word());
          write_reg(REG_ROT_X, trig_word());
          write_reg(REG_SCALE_X, $urandom_range(1) ? $urandom_range(1024) : $urandom);
          write_reg(REG_SCALE_Y, $urandom_range(1) ? $urandom_range(1024) : $urandom);
          write_reg(REG_SCALE_Z, $urandom);
          write_reg(REG_OFFSET_XY, $urandom);
          write_reg(REG_OFFSET_Z, $urandom);
        end
      endcase
      calm = (ph == 5);
      for (int n = 0; n < 152; n++) begin
        z = $urandom_range(3);
        vz = (z == 0) ? 16'(-1280 + $signed($urandom_range(64)) - 32) : 16'($urandom);
        send(16'($urandom), 16'($urandom), vz, 1'($urandom_range(1)), 1'b0, none);
      end
      calm = 1'b0;
      drain();
    end

    if (!failed && fixed_q.size() == 0) begin
      $display("vertex_rotate_project verification clean");
    end else begin
      $display("vertex_rotate_project verification failed");
    end
    $finish;
  end

endmodule
